### src/wmm_pkg.sv
// Package for the window min/max aggregator: field widths, codes, constants and
// the structs passed between the aggregator modules.
// No dependencies.
package wmm_pkg;

    // Field widths
    localparam int IVL_W   = 20;
    localparam int DELTA_W = 16;
    localparam int JERK_W  = 16;
    localparam int REG_W   = 2;
    localparam int LOOP_W  = 32;
    localparam int CNT_W   = 8;
    localparam int MS_W    = 8;
    localparam int LPK_W   = 16;

    // Packed stream widths (input padded to whole bytes)
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;

    // Action codes carried in the input tuser
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    // Regime codes
    localparam logic [REG_W-1:0] REGIME_STATIC  = 2'd0;
    localparam logic [REG_W-1:0] REGIME_DYNAMIC = 2'd1;
    localparam logic [REG_W-1:0] REGIME_SHOCK   = 2'd2;

    // Interval rounding: ms = (us + 500) / 1000, saturated at 255.
    // The quotient by 1000 is taken as (x >> 3) * 33555 >> 22, which is exact
    // for every x below the saturation limit.
    localparam logic [IVL_W:0]  IVL_ROUND_BIAS = 21'd500;
    localparam logic [IVL_W:0]  IVL_SAT_LIMIT  = 21'd255000;
    localparam logic [15:0]     IVL_RECIP      = 16'd33555;
    localparam int              IVL_RECIP_SH   = 22;
    localparam logic [MS_W-1:0] MS_SAT         = 8'd255;

    localparam logic [CNT_W-1:0] CNT_SAT  = 8'd255;
    localparam logic [LPK_W-1:0] LOOP_SAT = 16'hFFFF;

    // One sample after conversion
    typedef struct packed {
        logic                      action;
        logic signed [DELTA_W-1:0] delta_in;
        logic [JERK_W-1:0]         jerk_mag;
        logic [REG_W-1:0]          regime;
        logic [MS_W-1:0]           interval_ms;
        logic [LPK_W-1:0]          loop_us;
    } t_sample;

    // Snapshot of the window
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_min;
        logic signed [DELTA_W-1:0] delta_max;
        logic [JERK_W-1:0]         jerk_peak;
        logic [CNT_W-1:0]          static_count;
        logic [CNT_W-1:0]          dynamic_count;
        logic [CNT_W-1:0]          shock_count;
        logic [MS_W-1:0]           interval_peak_ms;
        logic [LPK_W-1:0]          loop_peak_us;
    } t_snapshot;

endpackage

### src/window_min_max_aggregator_top.sv
// Top level of the window min/max aggregator: input register, sample
// conversion, window state and output register. Depends on wmm_pkg,
// wmm_prep and wmm_accum.
//
//  channel | direction | word contents
//  --------+-----------+--------------------------------------------------------
//  s_axis  | in        | tuser: action; tdata: interval, delta, jerk, regime, loop
//  m_axis  | out       | tdata: snapshot of the window, one word per close
//
// Each word is held in the input register and then updates the window state; a
// close word, as it leaves the input register, loads the output register with the
// window snapshot. A new word is accepted every cycle unless the input register is held. Only a close word meeting a
// full, stalled output register holds the input register, and so s_axis_tready.
// Reset is synchronous and clears the window and both valid flags.
module window_min_max_aggregator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, from bit 0: interval_us[20], delta_in[16], jerk_value[16],
    // regime[2], loop_time_us[32], zero pad[2]
    input  logic [wmm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: action (0 add sample, 1 close window)
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, from bit 0: delta_min[16], delta_max[16], jerk_peak[16],
    // static_count[8], dynamic_count[8], shock_count[8], interval_peak_ms[8],
    // loop_peak_us[16]
    output logic [wmm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic                               r_in_valid;
    logic                               r_in_action;
    logic [85:0]                        r_in_data;
    logic                               r_out_valid;
    logic [wmm_pkg::OUT_TDATA_W-1:0]    r_out_data;

    logic               in_accept;
    logic               stage_go;
    wmm_pkg::t_sample   sample;
    wmm_pkg::t_snapshot snap;

    // A close word may move on only if the output register is free or draining
    assign stage_go = r_in_valid && (r_in_action == wmm_pkg::ACT_ADD
                                     || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || stage_go;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (stage_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_action <= s_axis_tuser;
            r_in_data   <= s_axis_tdata[85:0];
        end
    end

    wmm_prep u_prep (
        .i_action       (r_in_action),
        .i_interval_us  (r_in_data[19:0]),
        .i_delta_in     (r_in_data[35:20]),
        .i_jerk_value   (r_in_data[51:36]),
        .i_regime       (r_in_data[53:52]),
        .i_loop_time_us (r_in_data[85:54]),
        .o_sample       (sample)
    );

    wmm_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_go),
        .i_sample (sample),
        .o_snap   (snap)
    );

    // Output register, loaded by a close word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && r_in_action == wmm_pkg::ACT_CLOSE) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && r_in_action == wmm_pkg::ACT_CLOSE) begin
            r_out_data <= {snap.loop_peak_us, snap.interval_peak_ms, snap.shock_count,
                           snap.dynamic_count, snap.static_count, snap.jerk_peak,
                           snap.delta_max, snap.delta_min};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### src/wmm_prep.sv
// Sample conversion for the window aggregator: absolute jerk, interval rounded
// to milliseconds and saturated, loop time saturated. Depends on wmm_pkg.
module wmm_prep (
    input  logic                               i_action,
    input  logic [wmm_pkg::IVL_W-1:0]          i_interval_us,
    input  logic signed [wmm_pkg::DELTA_W-1:0] i_delta_in,
    input  logic signed [wmm_pkg::JERK_W-1:0]  i_jerk_value,
    input  logic [wmm_pkg::REG_W-1:0]          i_regime,
    input  logic [wmm_pkg::LOOP_W-1:0]         i_loop_time_us,
    output wmm_pkg::t_sample                   o_sample
);

    logic [wmm_pkg::IVL_W:0]   ivl_biased;
    logic [14:0]               ivl_eighth;
    logic [30:0]               ivl_prod;
    logic [wmm_pkg::MS_W-1:0]  ivl_ms;
    logic [wmm_pkg::JERK_W-1:0] jerk_mag;

    // Rounded milliseconds via reciprocal multiply, with saturation
    assign ivl_biased = {1'b0, i_interval_us} + wmm_pkg::IVL_ROUND_BIAS;
    assign ivl_eighth = ivl_biased[17:3];
    assign ivl_prod   = 31'(ivl_eighth * wmm_pkg::IVL_RECIP);
    assign ivl_ms     = (ivl_biased >= wmm_pkg::IVL_SAT_LIMIT) ? wmm_pkg::MS_SAT
                      : ivl_prod[wmm_pkg::IVL_RECIP_SH +: wmm_pkg::MS_W];

    // Absolute jerk; the most negative value maps to 32768, which fits unsigned
    assign jerk_mag = i_jerk_value[wmm_pkg::JERK_W-1] ? (~i_jerk_value + 16'd1)
                                                       : i_jerk_value;

    always_comb begin
        o_sample.action      = i_action;
        o_sample.delta_in    = i_delta_in;
        o_sample.jerk_mag    = jerk_mag;
        o_sample.regime      = i_regime;
        o_sample.interval_ms = ivl_ms;
        o_sample.loop_us     = (|i_loop_time_us[wmm_pkg::LOOP_W-1:wmm_pkg::LPK_W])
                             ? wmm_pkg::LOOP_SAT : i_loop_time_us[wmm_pkg::LPK_W-1:0];
    end

endmodule

### src/wmm_accum.sv
// Window state of the aggregator: running min/max, peaks and saturating
// regime counters, with the current snapshot as output. Depends on wmm_pkg.
module wmm_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wmm_pkg::t_sample   i_sample,
    output wmm_pkg::t_snapshot o_snap
);

    logic                               r_nonempty;
    logic signed [wmm_pkg::DELTA_W-1:0] r_min;
    logic signed [wmm_pkg::DELTA_W-1:0] r_max;
    logic [wmm_pkg::JERK_W-1:0]         r_jerk;
    logic [wmm_pkg::CNT_W-1:0]          r_cnt_static;
    logic [wmm_pkg::CNT_W-1:0]          r_cnt_dynamic;
    logic [wmm_pkg::CNT_W-1:0]          r_cnt_shock;
    logic [wmm_pkg::MS_W-1:0]           r_ivl;
    logic [wmm_pkg::LPK_W-1:0]          r_loop;

    // Update on each sample, clear when the window closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_sample.action == wmm_pkg::ACT_CLOSE)) begin
            r_nonempty    <= 1'b0;
            r_min         <= '0;
            r_max         <= '0;
            r_jerk        <= '0;
            r_cnt_static  <= '0;
            r_cnt_dynamic <= '0;
            r_cnt_shock   <= '0;
            r_ivl         <= '0;
            r_loop        <= '0;
        end else if (i_valid) begin
            r_nonempty <= 1'b1;
            if (!r_nonempty || i_sample.delta_in < r_min) begin
                r_min <= i_sample.delta_in;
            end
            if (!r_nonempty || i_sample.delta_in > r_max) begin
                r_max <= i_sample.delta_in;
            end
            if (!r_nonempty || i_sample.jerk_mag > r_jerk) begin
                r_jerk <= i_sample.jerk_mag;
            end
            case (i_sample.regime)
                wmm_pkg::REGIME_STATIC: begin
                    if (r_cnt_static != wmm_pkg::CNT_SAT) r_cnt_static <= r_cnt_static + 8'd1;
                end
                wmm_pkg::REGIME_DYNAMIC: begin
                    if (r_cnt_dynamic != wmm_pkg::CNT_SAT) begin
                        r_cnt_dynamic <= r_cnt_dynamic + 8'd1;
                    end
                end
                wmm_pkg::REGIME_SHOCK: begin
                    if (r_cnt_shock != wmm_pkg::CNT_SAT) r_cnt_shock <= r_cnt_shock + 8'd1;
                end
                default: begin
                end
            endcase
            if (i_sample.interval_ms > r_ivl) r_ivl <= i_sample.interval_ms;
            if (i_sample.loop_us > r_loop) r_loop <= i_sample.loop_us;
        end
    end

    // Snapshot of the state as it stands; the extrema registers are zero when empty
    always_comb begin
        o_snap.delta_min        = r_min;
        o_snap.delta_max        = r_max;
        o_snap.jerk_peak        = r_jerk;
        o_snap.static_count     = r_cnt_static;
        o_snap.dynamic_count    = r_cnt_dynamic;
        o_snap.shock_count      = r_cnt_shock;
        o_snap.interval_peak_ms = r_ivl;
        o_snap.loop_peak_us     = r_loop;
    end

endmodule

### src/wmm_checker.sv
// Port-level checks for the window min/max aggregator, bound to its top level.
// Depends on wmm_pkg and window_min_max_aggregator_top.
module wmm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [wmm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // The input side only stalls behind a stalled output word
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // The window minimum never exceeds its maximum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= $signed(m_axis_tdata[31:16]))
        else $error("snapshot minimum above maximum");

    // The jerk peak is an absolute 16-bit signed value, so at most 32768
    a_jerk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:32] <= 16'd32768)
        else $error("jerk peak out of range");

endmodule

bind window_min_max_aggregator_top wmm_checker u_wmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
